/* sv/tihc_pkg.sv */
// Package for the image header checker: verdict record, status codes,
// register indexes, reset values and the byte-wise CRC-32 update.
// No dependencies.
package tihc_pkg;

  localparam logic [31:0] MAGIC_RESET       = 32'h3052_4448;
  localparam logic [15:0] MAX_VERSION_RESET = 16'd2;
  localparam logic [31:0] CRC_POLY          = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT          = 32'hFFFF_FFFF;
  localparam logic [31:0] HEADER_BYTES      = 32'd32;
  localparam logic [31:0] CRC_START         = 32'd12;
  localparam logic [31:0] HEADER_LAST       = 32'd31;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_WORD  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_VERSION = 1'b1;

  typedef enum logic [2:0] {
    ST_VALID        = 3'd0,
    ST_NO_HEADER    = 3'd1,
    ST_BAD_VERSION  = 3'd2,
    ST_CRC_MISMATCH = 3'd3,
    ST_TRUNCATED    = 3'd4,
    ST_BAD_LENGTH   = 3'd5
  } status_t;

  // Packed with the first output field in the lowest bits.
  typedef struct packed {
    logic [31:0] image_length;
    logic [31:0] computed_crc;
    logic [31:0] header_position;
    logic [31:0] part_offset3;
    logic [31:0] part_offset2;
    logic [31:0] part_offset1;
    logic [31:0] part_offset0;
    logic [2:0]  part_count;
    logic [15:0] flags;
    logic [15:0] version;
    status_t     status;
  } verdict_t;

  localparam int VERDICT_W = $bits(verdict_t);
  localparam int TDATA_W   = ((VERDICT_W + 7) / 8) * 8;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* sv/trx_image_header_checker.sv */
// Image header checker, top level: configuration registers, front end and
// verdict queue. Depends on tihc_pkg, tihc_front and tihc_queue.
//
// The image enters on the s_axis channel, one byte per beat, with tlast on
// the final byte. The checker looks for the signature word at 4-byte-aligned
// offsets, captures the 32-byte header, runs CRC-32 from header offset 12 up to
// the image length in the length field, and gives one verdict per image on m_axis.
// A verdict is registered in the queue on the byte beat that decides it.
// The front end processes one byte per cycle; the CRC byte update and the
// field capture both complete in that cycle, so the rate is one byte per
// clock for as long as m_axis keeps up.
// When m_axis stalls, a two-entry queue holds verdicts; s_axis_tready drops
// only while both entries are full, and verdicts are never lost.
// Configuration is written via cfg_we, cfg_index and cfg_data; the user must
// write it only while the stream is idle, which is not checked. Synchronous
// reset clears parser and queue and sets magic_word and max_version to defaults.
// After tlast the parser rearms for the next image; registers keep values.
module trx_image_header_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // data_byte
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status, version, flags, part_count, part_offset0..3, header_position,
  // computed_crc, image_length, then zero fill
  output logic [tihc_pkg::TDATA_W-1:0]    m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [tihc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data
);
  import tihc_pkg::*;

  logic [31:0] magic_word;
  logic [15:0] max_version;
  logic        take;
  logic        push;
  verdict_t    push_data;
  verdict_t    out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word  <= MAGIC_RESET;
      max_version <= MAX_VERSION_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAGIC_WORD:  magic_word  <= cfg_data;
        CFG_MAX_VERSION: max_version <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign take = s_axis_tvalid && s_axis_tready;

  tihc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (s_axis_tdata),
    .last_byte     (s_axis_tlast),
    .magic_word    (magic_word),
    .max_version   (max_version),
    .verdict_valid (push),
    .verdict       (push_data)
  );

  tihc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (s_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (out_data)
  );

  assign m_axis_tdata = TDATA_W'(out_data);

`ifndef SYNTH
  a_full_means_pending : assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("queue full without a pending verdict");

  a_reset_empties : assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_axis_tvalid && s_axis_tready)
    else $error("queue not empty after reset");

  a_push_on_beat : assert property (@(posedge clk) disable iff (rst)
    push |-> take)
    else $error("verdict formed without an accepted byte");

  a_verdict_shows : assert property (@(posedge clk) disable iff (rst)
    push |=> m_axis_tvalid)
    else $error("verdict not presented after being formed");
`endif

endmodule

/* sv/tihc_front.sv */
// Front end of the image header checker: takes one byte per beat, hunts for
// the signature, captures the header, runs the CRC and forms the verdict.
// Depends on tihc_pkg.
module tihc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic [31:0]         magic_word,
  input  logic [15:0]         max_version,
  output logic                verdict_valid,
  output tihc_pkg::verdict_t  verdict
);
  import tihc_pkg::*;

  typedef enum logic [3:0] {
    PH_SEARCH = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_BODY   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] stream_position;
  logic [31:0] header_position, header_position_next;
  logic [31:0] word_shift, word_shift_next;
  logic [31:0] crc, crc_next;
  logic [31:0] length_field, length_field_next;
  logic [31:0] stored_crc, stored_crc_next;
  logic [31:0] ver_flags, ver_flags_next;
  logic [31:0] offsets [4];
  logic [31:0] offsets_next [4];

  logic [31:0] rel;
  logic [31:0] lane_value;
  logic [31:0] crc_byte_out;
  logic        emit;
  status_t     status;
  logic        none;

  always_comb begin
    rel          = stream_position - header_position;
    lane_value   = 32'(data_byte) << {rel[1:0], 3'b000};
    crc_byte_out = crc32_byte(crc, data_byte);

    phase_next           = phase;
    header_position_next = header_position;
    word_shift_next      = word_shift;
    crc_next             = crc;
    length_field_next    = length_field;
    stored_crc_next      = stored_crc;
    ver_flags_next       = ver_flags;
    for (int i = 0; i < 4; i++) begin
      offsets_next[i] = offsets[i];
    end
    emit   = 1'b0;
    status = ST_VALID;

    case (phase)
      PH_SEARCH: begin
        word_shift_next = {data_byte, word_shift[31:8]};
        if (stream_position[1:0] == 2'b11 && word_shift_next == magic_word) begin
          header_position_next = stream_position - 32'd3;
          crc_next             = CRC_INIT;
          phase_next           = PH_HEADER;
        end
      end
      PH_HEADER: begin
        case (rel[4:2])
          3'd0: ;
          3'd1: length_field_next = length_field | lane_value;
          3'd2: stored_crc_next   = stored_crc | lane_value;
          3'd3: ver_flags_next    = ver_flags | lane_value;
          default: offsets_next[rel[3:2]] = offsets[rel[3:2]] | lane_value;
        endcase
        if (rel >= CRC_START) begin
          crc_next = crc_byte_out;
        end
        if (rel >= HEADER_LAST) begin
          if (ver_flags_next[31:16] > max_version) begin
            emit   = 1'b1;
            status = ST_BAD_VERSION;
          end else if (length_field_next < HEADER_BYTES) begin
            emit   = 1'b1;
            status = ST_BAD_LENGTH;
          end else if (length_field_next == HEADER_BYTES) begin
            emit   = 1'b1;
            status = (crc_next == stored_crc_next) ? ST_VALID : ST_CRC_MISMATCH;
          end else begin
            phase_next = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        crc_next = crc_byte_out;
        if (rel == length_field - 32'd1) begin
          emit   = 1'b1;
          status = (crc_next == stored_crc) ? ST_VALID : ST_CRC_MISMATCH;
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    if (emit) begin
      phase_next = PH_DONE;
    end else if (last_byte && phase_next != PH_DONE) begin
      emit   = 1'b1;
      status = (phase_next == PH_SEARCH) ? ST_NO_HEADER : ST_TRUNCATED;
    end

    none = (status == ST_NO_HEADER);
    verdict.status          = status;
    verdict.version         = none ? 16'd0 : ver_flags_next[31:16];
    verdict.flags           = none ? 16'd0 : ver_flags_next[15:0];
    verdict.part_count      = none ? 3'd0 :
                              3'(offsets_next[0] != 32'd0) + 3'(offsets_next[1] != 32'd0) +
                              3'(offsets_next[2] != 32'd0) + 3'(offsets_next[3] != 32'd0);
    verdict.part_offset0    = none ? 32'd0 : offsets_next[0];
    verdict.part_offset1    = none ? 32'd0 : offsets_next[1];
    verdict.part_offset2    = none ? 32'd0 : offsets_next[2];
    verdict.part_offset3    = none ? 32'd0 : offsets_next[3];
    verdict.header_position = none ? 32'd0 : header_position_next;
    verdict.computed_crc    = none ? 32'd0 : crc_next;
    verdict.image_length    = none ? 32'd0 : length_field_next;
  end

  assign verdict_valid = take && emit;

  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      phase           <= PH_SEARCH;
      stream_position <= 32'd0;
      header_position <= 32'd0;
      word_shift      <= 32'd0;
      crc             <= CRC_INIT;
      length_field    <= 32'd0;
      stored_crc      <= 32'd0;
      ver_flags       <= 32'd0;
      for (int i = 0; i < 4; i++) begin
        offsets[i] <= 32'd0;
      end
    end else if (take) begin
      phase           <= phase_next;
      stream_position <= stream_position + 32'd1;
      header_position <= header_position_next;
      word_shift      <= word_shift_next;
      crc             <= crc_next;
      length_field    <= length_field_next;
      stored_crc      <= stored_crc_next;
      ver_flags       <= ver_flags_next;
      for (int i = 0; i < 4; i++) begin
        offsets[i] <= offsets_next[i];
      end
    end
  end

endmodule

/* sv/tihc_queue.sv */
// Two-entry verdict queue between the front end and the output channel:
// an output register plus one spare entry so both sides stall independently.
// Depends on tihc_pkg.
module tihc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tihc_pkg::verdict_t  push_data,
  output logic                push_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output tihc_pkg::verdict_t  out_data
);
  import tihc_pkg::*;

  verdict_t head;
  verdict_t spare;
  logic     head_valid;
  logic     spare_valid;
  logic     pop;

  assign push_ready = !spare_valid;
  assign out_valid  = head_valid;
  assign out_data   = head;
  assign pop        = head_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (pop && spare_valid) begin
      head        <= spare;
      spare_valid <= 1'b0;
    end else if (pop) begin
      head_valid <= push;
      head       <= push_data;
    end else if (push && !head_valid) begin
      head_valid <= 1'b1;
      head       <= push_data;
    end else if (push) begin
      spare_valid <= 1'b1;
      spare       <= push_data;
    end
  end

endmodule

/* sim/tb_trx_image_header_checker.sv */
// Testbench for trx_image_header_checker: streams generated images through the
// checker and compares every verdict with a behavioral predictor.
// Depends on tihc_pkg and the checker RTL.
module tb_trx_image_header_checker;
  timeunit 1ns;
  timeprecision 1ps;
  import tihc_pkg::*;

  typedef enum logic [1:0] {SCAN, HDR, BODY, DONE} parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } img_beat_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = 8'd0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]     m_axis_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_MAGIC_WORD;
  logic [31:0]            cfg_data = 32'd0;

  img_beat_t   beats_pending[$];
  verdict_t    verdicts_due[$];
  img_beat_t   next_beat;
  int unsigned beats_queued = 0;
  int unsigned beats_taken = 0;
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  parse_phase_t     cur_phase;
  logic [31:0]      byte_pos, hdr_pos, sig_shift, crc_acc;
  logic [31:0]      len_word, crc_word, fv_word;
  logic [3:0][31:0] part_offs;
  logic [31:0]      magic_cfg;
  logic [15:0]      max_ver_cfg;

  trx_image_header_checker dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // data_byte
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // status, version, flags, part_count, part_offset0..3, header_position,
    // computed_crc, image_length, then zero fill
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
    logic fb;
    int   k;
    for (k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c  = c >> 1;
      if (fb) c = c ^ 32'hEDB8_8320;
    end
    return c;
  endfunction

  function automatic void rearm_parser();
    cur_phase = SCAN;
    byte_pos  = '0;
    hdr_pos   = '0;
    sig_shift = '0;
    crc_acc   = '1;
    len_word  = '0;
    crc_word  = '0;
    fv_word   = '0;
    part_offs = '0;
  endfunction

  function automatic void emit_verdict(input status_t st);
    verdict_t v;
    int       i;
    v = '0;
    v.status = st;
    if (st != ST_NO_HEADER) begin
      v.version = fv_word[31:16];
      v.flags   = fv_word[15:0];
      for (i = 0; i < 4; i++)
        if (part_offs[i] != 32'd0) v.part_count = v.part_count + 3'd1;
      v.part_offset0    = part_offs[0];
      v.part_offset1    = part_offs[1];
      v.part_offset2    = part_offs[2];
      v.part_offset3    = part_offs[3];
      v.header_position = hdr_pos;
      v.computed_crc    = crc_acc;
      v.image_length    = len_word;
    end
    verdicts_due.push_back(v);
    cur_phase = DONE;
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic last);
    logic [31:0] rel;
    logic [31:0] lane;
    rel = byte_pos - hdr_pos;
    case (cur_phase)
      SCAN: begin
        sig_shift = {b, sig_shift[31:8]};
        if (byte_pos[1:0] == 2'd3 && sig_shift == magic_cfg) begin
          hdr_pos   = byte_pos - 32'd3;
          crc_acc   = '1;
          cur_phase = HDR;
        end
      end
      HDR: begin
        lane = {24'd0, b} << (8 * rel[1:0]);
        case (rel[4:2])
          3'd1:    len_word = len_word | lane;
          3'd2:    crc_word = crc_word | lane;
          3'd3:    fv_word = fv_word | lane;
          3'd0:    ;
          default: part_offs[rel[3:2]] = part_offs[rel[3:2]] | lane;
        endcase
        if (rel >= 32'd12) crc_acc = crc32_step(crc_acc, b);
        if (rel >= 32'd31) begin
          if (fv_word[31:16] > max_ver_cfg) emit_verdict(ST_BAD_VERSION);
          else if (len_word < 32'd32) emit_verdict(ST_BAD_LENGTH);
          else if (len_word == 32'd32)
            emit_verdict(crc_acc == crc_word ? ST_VALID : ST_CRC_MISMATCH);
          else cur_phase = BODY;
        end
      end
      BODY: begin
        crc_acc = crc32_step(crc_acc, b);
        if (rel == len_word - 32'd1)
          emit_verdict(crc_acc == crc_word ? ST_VALID : ST_CRC_MISMATCH);
      end
      default: ;
    endcase
    byte_pos = byte_pos + 32'd1;
    if (last) begin
      if (cur_phase != DONE) emit_verdict(cur_phase == SCAN ? ST_NO_HEADER : ST_TRUNCATED);
      rearm_parser();
    end
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s: got 0x%08h, expected 0x%08h", name, got, want));
  endtask

  task automatic check_verdict(input verdict_t got);
    verdict_t want;
    if (verdicts_due.size() == 0) begin
      flag_error("verdict beat with no verdict pending");
    end else begin
      want = verdicts_due.pop_front();
      check_field("status", {29'd0, got.status}, {29'd0, want.status});
      check_field("version", {16'd0, got.version}, {16'd0, want.version});
      check_field("flags", {16'd0, got.flags}, {16'd0, want.flags});
      check_field("part_count", {29'd0, got.part_count}, {29'd0, want.part_count});
      check_field("part_offset0", got.part_offset0, want.part_offset0);
      check_field("part_offset1", got.part_offset1, want.part_offset1);
      check_field("part_offset2", got.part_offset2, want.part_offset2);
      check_field("part_offset3", got.part_offset3, want.part_offset3);
      check_field("header_position", got.header_position, want.header_position);
      check_field("computed_crc", got.computed_crc, want.computed_crc);
      check_field("image_length", got.image_length, want.image_length);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (beats_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_beat = beats_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_beat.data;
        s_axis_tlast  <= next_beat.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        beats_taken++;
        predict_byte(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) check_verdict(verdict_t'(m_axis_tdata[VERDICT_W-1:0]));
    end
  end

  task automatic add_image(input int unsigned pre, input bit with_hdr, input logic [31:0] len,
                           input bit crc_ok, input logic [31:0] fv,
                           input logic [3:0][31:0] offs, input int unsigned trail,
                           input int cut);
    logic [7:0]  img[$];
    logic [31:0] hw[8];
    logic [31:0] sum;
    int unsigned hb, body_n, i, k;
    img_beat_t   bt;
    for (i = 0; i < pre; i++) img.push_back(8'($urandom));
    if (with_hdr) begin
      hb    = img.size();
      hw[0] = magic_cfg;
      hw[1] = len;
      hw[2] = 32'd0;
      hw[3] = fv;
      for (i = 0; i < 4; i++) hw[4 + i] = offs[i];
      for (i = 0; i < 8; i++)
        for (k = 0; k < 4; k++) img.push_back(hw[i][8 * k +: 8]);
      body_n = (len > 32'd48) ? 16 : ((len > 32'd32) ? len - 32'd32 : 0);
      for (i = 0; i < body_n; i++) img.push_back(8'($urandom));
      sum = '1;
      for (i = hb + 12; i < img.size(); i++) sum = crc32_step(sum, img[i]);
      if (!crc_ok) sum = sum ^ (32'd1 << $urandom_range(31));
      for (k = 0; k < 4; k++) img[hb + 8 + k] = sum[8 * k +: 8];
    end
    for (i = 0; i < trail; i++) img.push_back(8'($urandom));
    if (cut > 0)
      while (img.size() > cut) void'(img.pop_back());
    for (i = 0; i < img.size(); i++) begin
      bt.data = img[i];
      bt.last = (i == img.size() - 1);
      beats_pending.push_back(bt);
    end
    beats_queued += img.size();
  endtask

  task automatic add_random_image();
    int unsigned      kind, sub, pre, i;
    logic [31:0]      len, fv;
    logic [3:0][31:0] offs;
    int               cut;
    kind = $urandom_range(99);
    for (i = 0; i < 4; i++)
      offs[i] = $urandom_range(1) ? 32'd0 : ($urandom_range(7) == 0 ? '1 : $urandom);
    fv  = {16'($urandom_range(max_ver_cfg)), 16'($urandom)};
    len = 32'd32 + $urandom_range(16);
    cut = -1;
    if (kind < 12) begin
      add_image($urandom_range(12, 1), 1'b0, len, 1'b1, fv, offs, 0, -1);
    end else if (kind < 22) begin
      pre = 4 * $urandom_range(2) + $urandom_range(3, 1);
      add_image(pre, 1'b1, len, 1'b1, fv, offs, $urandom_range(3), -1);
    end else begin
      pre = 4 * $urandom_range(3);
      sub = $urandom_range(99);
      if (sub < 10) begin
        if (max_ver_cfg != 16'hFFFF) fv[31:16] = 16'($urandom_range(65535, max_ver_cfg + 1));
      end else if (sub < 16) begin
        len = $urandom_range(31);
      end else if (sub < 20) begin
        len = $urandom | 32'h8000_0000;
      end
      if ($urandom_range(99) < 15) cut = $urandom_range(pre + 50, 1);
      add_image(pre, 1'b1, len, $urandom_range(99) >= 15, fv, offs, $urandom_range(4), cut);
    end
  endtask

  task automatic wait_idle();
    while (beats_taken != beats_queued || verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAGIC_WORD) magic_cfg = val;
    else max_ver_cfg = val[15:0];
  endtask

  task automatic run_random(input int unsigned min_bytes, input int unsigned min_images);
    int unsigned start, n;
    start = beats_queued;
    n     = 0;
    while (beats_queued - start < min_bytes || n < min_images) begin
      add_random_image();
      n++;
      // Hold the stream back until every verdict so far has come out.
      if (n == min_images / 2) wait_idle();
    end
    wait_idle();
  endtask

  initial begin
    rearm_parser();
    magic_cfg   = 32'h3052_4448;
    max_ver_cfg = 16'd2;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    add_image(1, 1'b0, 0, 1'b1, 0, '0, 0, -1);
    add_image(9, 1'b0, 0, 1'b1, 0, '0, 0, -1);
    add_image(0, 1'b1, 32, 1'b1, {16'd0, 16'h0000}, '0, 0, -1);
    add_image(4, 1'b1, 44, 1'b1, {16'd2, 16'hFFFF}, {4{32'hFFFF_FFFF}}, 3, -1);
    add_image(8, 1'b1, 37, 1'b1, {16'd1, 16'h8001}, {32'h0, 32'h40, 32'h0, 32'h1C}, 0, -1);
    add_image(0, 1'b1, 36, 1'b0, {16'd1, 16'h0100}, {32'h1, 32'h2, 32'h3, 32'h4}, 2, -1);
    add_image(0, 1'b1, 40, 1'b1, {16'd3, 16'h0000}, '0, 4, -1);
    add_image(4, 1'b1, 40, 1'b1, {16'hFFFF, 16'h1234}, '0, 0, -1);
    add_image(0, 1'b1, 0, 1'b1, {16'd0, 16'h0001}, '0, 2, -1);
    add_image(0, 1'b1, 31, 1'b1, {16'd2, 16'h0000}, {32'h0, 32'h0, 32'h0, 32'h5}, 0, -1);
    add_image(0, 1'b1, 32'hFFFF_FFFF, 1'b1, {16'd1, 16'h00FF}, '0, 0, -1);
    add_image(4, 1'b1, 40, 1'b1, {16'd1, 16'h0000}, '0, 0, 8);
    add_image(0, 1'b1, 40, 1'b1, {16'd1, 16'h0000}, {4{32'h0101_0101}}, 0, 20);
    add_image(0, 1'b1, 48, 1'b1, {16'd0, 16'hAAAA}, {32'h30, 32'h0, 32'h0, 32'h0}, 0, 40);
    add_image(2, 1'b1, 36, 1'b1, {16'd1, 16'h0000}, '0, 0, -1);
    add_image(3, 1'b1, 36, 1'b1, {16'd1, 16'h0000}, '0, 1, -1);
    wait_idle();

    set_reg(CFG_MAX_VERSION, 32'h0000_FFFF);
    set_reg(CFG_MAGIC_WORD, 32'h3052_4448);
    run_random(160, 4);

    send_idle_pct = 78;
    set_reg(CFG_MAGIC_WORD, 32'h0000_0000);
    set_reg(CFG_MAX_VERSION, 32'd0);
    run_random(160, 4);

    send_idle_pct = 0;
    stall_pct     = 78;
    set_reg(CFG_MAGIC_WORD, 32'hFFFF_FFFF);
    set_reg(CFG_MAX_VERSION, {16'd0, 16'($urandom)});
    run_random(160, 4);

    send_idle_pct = 26;
    stall_pct     = 26;
    set_reg(CFG_MAGIC_WORD, $urandom);
    set_reg(CFG_MAX_VERSION, 32'd2);
    run_random(160, 4);

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_trx_image_header_checker: done, clean");
    end else begin
      $display("tb_trx_image_header_checker: done, errors");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb_trx_image_header_checker: done, errors");
    $finish;
  end

endmodule
